// File: hw/rtl/pwlc_pkg.sv
// ----------------------------------------------------------------------------
// pwlc_pkg
// Shared types, constants and helper functions for the power window lift
// controller.
// ----------------------------------------------------------------------------
package pwlc_pkg;

  localparam int unsigned PinW   = 8;
  localparam int unsigned BtnN   = 4;
  localparam int unsigned SiW    = 8;
  localparam int unsigned HoldW  = 16;
  localparam int unsigned RevW   = 24;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW   = 24;

  // register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] REG_SAMPLE_INTERVAL = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_HOLD_TICKS      = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_REVERSE_TICKS   = 2'd2;

  localparam logic [SiW-1:0]   SAMPLE_INTERVAL_RST = 8'd5;
  localparam logic [HoldW-1:0] HOLD_TICKS_RST      = 16'd200;
  localparam logic [RevW-1:0]  REVERSE_TICKS_RST   = 24'd1000000;

  // pin positions (active low at the port)
  localparam int unsigned JAM_PIN  = 6;
  localparam int unsigned LOCK_PIN = 7;

  // lamp colors
  localparam logic [1:0] LAMP_GREEN = 2'd0;
  localparam logic [1:0] LAMP_RED   = 2'd1;
  localparam logic [1:0] LAMP_BLUE  = 2'd2;
  localparam logic [1:0] LAMP_WHITE = 2'd3;

  // requests: pass up, pass down, drv up, drv down
  localparam logic [1:0] REQ_PASS_UP   = 2'd0;
  localparam logic [1:0] REQ_PASS_DOWN = 2'd1;
  localparam logic [1:0] REQ_DRV_UP    = 2'd2;
  localparam logic [1:0] REQ_DRV_DOWN  = 2'd3;

  // pressed pins that end a run, per request
  localparam logic [PinW-1:0] MANUAL_BLOCK [BtnN] = '{8'h9C, 8'hAC, 8'h10, 8'h20};
  localparam logic [PinW-1:0] AUTO_BLOCK   [BtnN] = '{8'h9E, 8'hAD, 8'h18, 8'h24};

  typedef enum logic [3:0] {
    PH_NEUTRAL   = 4'd0,
    PH_WAIT_PU   = 4'd1,
    PH_WAIT_PD   = 4'd2,
    PH_WAIT_DU   = 4'd3,
    PH_WAIT_DD   = 4'd4,
    PH_RUN_PU    = 4'd5,
    PH_RUN_PD    = 4'd6,
    PH_RUN_DU    = 4'd7,
    PH_RUN_DD    = 4'd8,
    PH_JAM       = 4'd9
  } phase_t;

  typedef struct packed {
    logic       press;
    logic [1:0] req;
  } press_t;

  typedef struct packed {
    logic       motor_down;
    logic       motor_up;
    logic [1:0] lamp;
    logic [3:0] phase;
    logic       auto_mode;
  } result_t;

  function automatic phase_t wait_phase(input logic [1:0] req);
    phase_t ph;
    case (req)
      REQ_PASS_UP:   ph = PH_WAIT_PU;
      REQ_PASS_DOWN: ph = PH_WAIT_PD;
      REQ_DRV_UP:    ph = PH_WAIT_DU;
      default:       ph = PH_WAIT_DD;
    endcase
    return ph;
  endfunction

  function automatic phase_t run_phase(input logic [1:0] req);
    phase_t ph;
    case (req)
      REQ_PASS_UP:   ph = PH_RUN_PU;
      REQ_PASS_DOWN: ph = PH_RUN_PD;
      REQ_DRV_UP:    ph = PH_RUN_DU;
      default:       ph = PH_RUN_DD;
    endcase
    return ph;
  endfunction

  // run may continue / start with this set of pressed pins
  function automatic logic run_ok(input logic [1:0] req, input logic [PinW-1:0] pressed,
                                  input logic autom);
    logic ok;
    if (autom) begin
      ok = (pressed & AUTO_BLOCK[req]) == '0;
    end else begin
      ok = pressed[req] && ((pressed & MANUAL_BLOCK[req]) == '0);
    end
    return ok;
  endfunction

endpackage

// File: hw/rtl/pwlc_debounce.sv
// ----------------------------------------------------------------------------
// pwlc_debounce
// Samples the four request buttons every sample_interval items and reports
// the first new debounced press (two agreeing samples).
// ----------------------------------------------------------------------------
module pwlc_debounce (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic [pwlc_pkg::SiW-1:0]     sample_interval,
  input  logic [pwlc_pkg::BtnN-1:0]    buttons,
  output pwlc_pkg::press_t             ev
);
  import pwlc_pkg::*;

  logic [BtnN-1:0] debounced, debounced_next;
  logic [BtnN-1:0] last_sample, last_sample_next;
  logic [SiW-1:0]  sample_count, sample_count_next;
  logic [BtnN-1:0] changed;
  logic            found;

  always_comb begin
    debounced_next   = debounced;
    last_sample_next = last_sample;
    ev               = '0;
    changed          = '0;
    found            = 1'b0;
    if (sample_count != '0) begin
      sample_count_next = sample_count - 1'b1;
    end else begin
      sample_count_next = (sample_interval == '0) ? '0 : sample_interval - 1'b1;
      debounced_next    = (debounced | (last_sample & buttons)) & (last_sample | buttons);
      last_sample_next  = buttons;
      changed           = debounced ^ debounced_next;
      // only the first changed button counts; a release reports nothing
      for (int i = 0; i < BtnN; i++) begin
        if (!found && changed[i]) begin
          found    = 1'b1;
          ev.press = debounced_next[i];
          ev.req   = 2'(i);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounced    <= '0;
      last_sample  <= '0;
      sample_count <= '0;
    end else if (step) begin
      debounced    <= debounced_next;
      last_sample  <= last_sample_next;
      sample_count <= sample_count_next;
    end
  end

endmodule

// File: hw/rtl/pwlc_ctrl.sv
// ----------------------------------------------------------------------------
// pwlc_ctrl
// Window lift state machine: waiting, manual/auto runs and jam reverse,
// plus the result of each tick.
// ----------------------------------------------------------------------------
module pwlc_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic [pwlc_pkg::PinW-1:0]     pins_n,
  input  pwlc_pkg::press_t              ev,
  input  logic [pwlc_pkg::HoldW-1:0]    hold_ticks,
  input  logic [pwlc_pkg::RevW-1:0]     reverse_ticks,
  output pwlc_pkg::result_t             result_next
);
  import pwlc_pkg::*;

  phase_t           state, state_next, cur;
  phase_t           shown;
  logic [HoldW-1:0] hold_count, hold_count_next, hc;
  logic [RevW-1:0]  reverse_count, reverse_count_next, rc;
  logic             run_is_auto, run_is_auto_next, ra;
  logic             last_jam_level;
  logic [PinW-1:0]  pressed;
  logic             jam_entry;
  logic             autom;
  logic [3:0]       cur_code, wait_diff, run_diff, next_code, next_run_diff;

  assign pressed   = ~pins_n;
  assign jam_entry = last_jam_level && !pins_n[JAM_PIN] && (state != PH_JAM);

  // next state
  always_comb begin
    cur = jam_entry ? PH_JAM : state;
    rc  = jam_entry ? ((reverse_ticks == '0) ? RevW'(1) : reverse_ticks) : reverse_count;
    hc  = jam_entry ? '0 : hold_count;
    ra  = jam_entry ? 1'b0 : run_is_auto;
    cur_code  = cur;
    wait_diff = cur_code - PH_WAIT_PU;
    run_diff  = cur_code - PH_RUN_PU;
    autom     = !pressed[wait_diff[1:0]];

    state_next         = cur;
    reverse_count_next = rc;
    hold_count_next    = hc;
    run_is_auto_next   = ra;

    case (cur)
      PH_JAM: begin
        if (rc <= RevW'(1)) begin
          reverse_count_next = '0;
          state_next         = PH_NEUTRAL;
        end else begin
          reverse_count_next = rc - 1'b1;
        end
      end
      PH_NEUTRAL: begin
        if (ev.press && !(!ev.req[1] && pressed[LOCK_PIN])) begin
          state_next      = wait_phase(ev.req);
          hold_count_next = (hold_ticks == '0) ? HoldW'(1) : hold_ticks;
        end
      end
      PH_WAIT_PU, PH_WAIT_PD, PH_WAIT_DU, PH_WAIT_DD: begin
        if (hc <= HoldW'(1)) begin
          hold_count_next = '0;
          if (run_ok(wait_diff[1:0], pressed, autom)) begin
            state_next       = run_phase(wait_diff[1:0]);
            run_is_auto_next = autom;
          end else begin
            state_next       = PH_NEUTRAL;
            run_is_auto_next = 1'b0;
          end
        end else begin
          hold_count_next = hc - 1'b1;
        end
      end
      PH_RUN_PU, PH_RUN_PD, PH_RUN_DU, PH_RUN_DD: begin
        if (!run_ok(run_diff[1:0], pressed, ra)) begin
          state_next       = PH_NEUTRAL;
          run_is_auto_next = 1'b0;
        end
      end
      default: begin
        state_next       = PH_NEUTRAL;
        run_is_auto_next = 1'b0;
      end
    endcase
  end

  // outputs, taken after the update; every reverse tick, the last included,
  // still shows the jam reverse
  always_comb begin
    shown         = (cur == PH_JAM) ? PH_JAM : state_next;
    next_code     = shown;
    next_run_diff = next_code - PH_RUN_PU;
    result_next   = '0;
    result_next.phase = next_code;
    case (shown)
      PH_JAM: begin
        result_next.motor_down = 1'b1;
        result_next.lamp       = LAMP_WHITE;
      end
      PH_RUN_PU, PH_RUN_PD, PH_RUN_DU, PH_RUN_DD: begin
        // odd requests lower the window
        if (next_run_diff[0]) begin
          result_next.motor_down = 1'b1;
          result_next.lamp       = LAMP_RED;
        end else begin
          result_next.motor_up = 1'b1;
          result_next.lamp     = LAMP_BLUE;
        end
        result_next.auto_mode = run_is_auto_next;
      end
      default: begin
        result_next.lamp = LAMP_GREEN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= PH_NEUTRAL;
      hold_count     <= '0;
      reverse_count  <= '0;
      run_is_auto    <= 1'b0;
      last_jam_level <= 1'b1;
    end else if (step) begin
      state          <= state_next;
      hold_count     <= hold_count_next;
      reverse_count  <= reverse_count_next;
      run_is_auto    <= run_is_auto_next;
      last_jam_level <= pins_n[JAM_PIN];
    end
  end

endmodule

// File: hw/rtl/power_window_lift_controller_top.sv
// ----------------------------------------------------------------------------
// power_window_lift_controller_top
// Power window lift controller: debounced request buttons, manual and
// one-touch runs, limit/lock stops and jam reverse. One item is one tick.
// ----------------------------------------------------------------------------
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_ready, pins_n[7:0]           | sink
//  out     | out_valid, out_ready, motor_down,         | source
//          | motor_up, lamp[1:0], phase[3:0], auto_mode|
//  cfg     | cfg_valid, cfg_ready, cfg_index[1:0],     | sink
//          | cfg_data[23:0]                            |
//
//  Throughput is one item per cycle while the result register is free or being
//  taken; an accepted item passes the input register, then the result register.
//  The tick update is one pass of short logic between the input register and
//  the result register, so the input register empties whenever the result
//  register is free or being taken in the same cycle.
//  Synchronous active-high reset clears handshake, state and the registers to
//  their defaults (5, 200, 1000000); there is no clearing pass.
//  cfg_ready is always high; writes are expected only while the block is idle.
// ----------------------------------------------------------------------------
module power_window_lift_controller_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [pwlc_pkg::PinW-1:0]       pins_n,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            motor_down,
  output logic                            motor_up,
  output logic [1:0]                      lamp,
  output logic [3:0]                      phase,
  output logic                            auto_mode,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pwlc_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [pwlc_pkg::CfgW-1:0]       cfg_data
);
  import pwlc_pkg::*;

  // configuration registers
  logic [SiW-1:0]   sample_interval;
  logic [HoldW-1:0] hold_ticks;
  logic [RevW-1:0]  reverse_ticks;

  // input register
  logic             item_valid;
  logic [PinW-1:0]  item_pins;

  // result register
  result_t          result;
  result_t          result_next;

  press_t           ev;
  logic             advance;

  assign cfg_ready = 1'b1;

  // the tick is processed when the result register can take it
  assign advance  = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_interval <= SAMPLE_INTERVAL_RST;
      hold_ticks      <= HOLD_TICKS_RST;
      reverse_ticks   <= REVERSE_TICKS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SAMPLE_INTERVAL: sample_interval <= cfg_data[SiW-1:0];
        REG_HOLD_TICKS:      hold_ticks      <= cfg_data[HoldW-1:0];
        REG_REVERSE_TICKS:   reverse_ticks   <= cfg_data[RevW-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_pins <= pins_n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  pwlc_debounce u_debounce (
    .clk             (clk),
    .rst             (rst),
    .step            (advance),
    .sample_interval (sample_interval),
    .buttons         (~item_pins[BtnN-1:0]),
    .ev              (ev)
  );

  pwlc_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .pins_n        (item_pins),
    .ev            (ev),
    .hold_ticks    (hold_ticks),
    .reverse_ticks (reverse_ticks),
    .result_next   (result_next)
  );

  assign motor_down = result.motor_down;
  assign motor_up   = result.motor_up;
  assign lamp       = result.lamp;
  assign phase      = result.phase;
  assign auto_mode  = result.auto_mode;

endmodule

// File: hw/rtl/pwlc_checker.sv
// ----------------------------------------------------------------------------
// pwlc_checker
// Port-level checks on the result channel of the window lift controller.
// ----------------------------------------------------------------------------
module pwlc_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       motor_down,
  input logic       motor_up,
  input logic [1:0] lamp,
  input logic [3:0] phase,
  input logic       auto_mode
);
  import pwlc_pkg::*;

  // motor never driven both ways
  a_motor_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(motor_down && motor_up))
    else $error("motor driven up and down at once");

  // white lamp only in jam reverse, and then lowering
  a_jam_lamp: assert property (@(posedge clk) disable iff (rst)
    (out_valid && lamp == LAMP_WHITE) |-> (phase == PH_JAM && motor_down && !auto_mode))
    else $error("white lamp outside jam reverse");

  // automatic flag only while the motor runs
  a_auto_runs: assert property (@(posedge clk) disable iff (rst)
    (out_valid && auto_mode) |-> (motor_down || motor_up))
    else $error("auto mode with motor stopped");

  // neutral and waiting phases keep the motor off
  a_idle_off: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (phase == PH_NEUTRAL || phase == PH_WAIT_PU || phase == PH_WAIT_PD ||
                   phase == PH_WAIT_DU || phase == PH_WAIT_DD))
      |-> (!motor_down && !motor_up && lamp == LAMP_GREEN))
    else $error("motor on outside run or jam phase");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(phase) && $stable(lamp)))
    else $error("stalled result changed");

endmodule

bind power_window_lift_controller_top pwlc_checker u_pwlc_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .motor_down (motor_down),
  .motor_up   (motor_up),
  .lamp       (lamp),
  .phase      (phase),
  .auto_mode  (auto_mode)
);

// File: tb/power_window_lift_controller_checker.sv
// ----------------------------------------------------------------------------
// power_window_lift_controller_checker
// Watches the tick, result and register channels of the window lift
// controller, predicts the motor/lamp/phase outputs of every accepted tick
// and compares them in order with the results the block hands out.
// ----------------------------------------------------------------------------
module power_window_lift_controller_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [pwlc_pkg::PinW-1:0]     pins_n,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic                          motor_down,
  input  logic                          motor_up,
  input  logic [1:0]                    lamp,
  input  logic [3:0]                    phase,
  input  logic                          auto_mode,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [pwlc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [pwlc_pkg::CfgW-1:0]     cfg_data,
  output int unsigned                   fails,
  output int unsigned                   pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import pwlc_pkg::*;

  // register copies
  logic [SiW-1:0]   cfg_si;
  logic [HoldW-1:0] cfg_hold;
  logic [RevW-1:0]  cfg_rev;

  // controller copy
  phase_t           ph;
  logic [BtnN-1:0]  btn_db;
  logic [BtnN-1:0]  btn_prev;
  logic [SiW-1:0]   smp_cnt;
  logic [HoldW-1:0] hold_cnt;
  logic             run_auto;
  logic [RevW-1:0]  rev_cnt;
  logic             jam_prev;

  result_t          due_outputs [$];
  int unsigned      checked;

  function automatic void clear_controller();
    cfg_si   = SAMPLE_INTERVAL_RST;
    cfg_hold = HOLD_TICKS_RST;
    cfg_rev  = REVERSE_TICKS_RST;
    ph       = PH_NEUTRAL;
    btn_db   = '0;
    btn_prev = '0;
    smp_cnt  = '0;
    hold_cnt = '0;
    run_auto = 1'b0;
    rev_cnt  = '0;
    jam_prev = 1'b1;
  endfunction

  function automatic logic run_allowed(input logic [1:0] req, input logic [PinW-1:0] held,
                                       input logic one_touch);
    if (one_touch)
      return (held & AUTO_BLOCK[req]) == '0;
    return held[req] && ((held & MANUAL_BLOCK[req]) == '0);
  endfunction

  // {new press, request}; only the lowest changed button counts
  function automatic logic [2:0] debounce_sample(input logic [BtnN-1:0] cur);
    logic [BtnN-1:0] was;
    logic [BtnN-1:0] flips;
    logic [2:0]      press;
    press = 3'b000;
    if (smp_cnt != '0) begin
      smp_cnt = smp_cnt - 1'b1;
      return press;
    end
    smp_cnt  = (cfg_si == '0) ? '0 : cfg_si - 1'b1;
    was      = btn_db;
    btn_db   = (btn_db | (btn_prev & cur)) & (btn_prev | cur);
    btn_prev = cur;
    flips    = was ^ btn_db;
    for (int i = BtnN - 1; i >= 0; i--) begin
      if (flips[i])
        press = {btn_db[i], 2'(i)};
    end
    return press;
  endfunction

  function automatic result_t lift_tick(input logic [PinW-1:0] pins);
    logic [PinW-1:0] held;
    logic            jam_fell;
    logic [2:0]      press;
    logic [1:0]      req;
    logic            one_touch;
    logic            down;
    result_t         r;
    held     = ~pins;
    jam_fell = jam_prev && !pins[JAM_PIN];
    jam_prev = pins[JAM_PIN];
    press    = debounce_sample(held[BtnN-1:0]);
    r        = '0;

    if (jam_fell && ph != PH_JAM) begin
      ph       = PH_JAM;
      rev_cnt  = (cfg_rev == '0) ? RevW'(1) : cfg_rev;
      run_auto = 1'b0;
      hold_cnt = '0;
    end

    if (ph == PH_JAM) begin
      if (rev_cnt <= RevW'(1)) begin
        rev_cnt = '0;
        ph      = PH_NEUTRAL;
      end else begin
        rev_cnt = rev_cnt - 1'b1;
      end
      r.motor_down = 1'b1;
      r.lamp       = LAMP_WHITE;
      r.phase      = PH_JAM;
      return r;
    end

    if (ph == PH_NEUTRAL) begin
      req = press[1:0];
      // passenger presses are refused under lock
      if (press[2] && !((req == REQ_PASS_UP || req == REQ_PASS_DOWN) && held[LOCK_PIN])) begin
        ph       = phase_t'(PH_WAIT_PU + 4'(req));
        hold_cnt = (cfg_hold == '0) ? HoldW'(1) : cfg_hold;
      end
    end else if (ph >= PH_WAIT_PU && ph <= PH_WAIT_DD) begin
      if (hold_cnt <= HoldW'(1)) begin
        hold_cnt  = '0;
        req       = 2'(ph - PH_WAIT_PU);
        one_touch = !held[req];
        if (run_allowed(req, held, one_touch)) begin
          ph       = phase_t'(PH_RUN_PU + 4'(req));
          run_auto = one_touch;
        end else begin
          ph       = PH_NEUTRAL;
          run_auto = 1'b0;
        end
      end else begin
        hold_cnt = hold_cnt - 1'b1;
      end
    end else if (ph >= PH_RUN_PU && ph <= PH_RUN_DD) begin
      if (!run_allowed(2'(ph - PH_RUN_PU), held, run_auto)) begin
        ph       = PH_NEUTRAL;
        run_auto = 1'b0;
      end
    end else begin
      ph       = PH_NEUTRAL;
      run_auto = 1'b0;
    end

    r.phase = ph;
    if (ph >= PH_RUN_PU && ph <= PH_RUN_DD) begin
      req          = 2'(ph - PH_RUN_PU);
      down         = (req == REQ_PASS_DOWN || req == REQ_DRV_DOWN);
      r.motor_down = down;
      r.motor_up   = !down;
      r.lamp       = down ? LAMP_RED : LAMP_BLUE;
      r.auto_mode  = run_auto;
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    result_t seen;
    result_t want;
    if (rst) begin
      clear_controller();
      due_outputs.delete();
      fails   <= 0;
      checked <= 0;
    end else begin
      // result first: a tick accepted at this edge can't be on the output yet
      if (out_valid && out_ready) begin
        seen = {motor_down, motor_up, lamp, phase, auto_mode};
        if (due_outputs.size() == 0) begin
          if (fails < 10)
            $display("result %0d with nothing expected: down=%0b up=%0b lamp=%0d phase=%0d auto=%0b",
                     checked, seen.motor_down, seen.motor_up, seen.lamp, seen.phase,
                     seen.auto_mode);
          fails <= fails + 1;
        end else begin
          want = due_outputs.pop_front();
          if (seen !== want) begin
            if (fails < 10)
              $display({"result %0d mismatch: expected down=%0b up=%0b lamp=%0d phase=%0d ",
                        "auto=%0b, got down=%0b up=%0b lamp=%0d phase=%0d auto=%0b"},
                       checked, want.motor_down, want.motor_up, want.lamp, want.phase,
                       want.auto_mode, seen.motor_down, seen.motor_up, seen.lamp,
                       seen.phase, seen.auto_mode);
            fails <= fails + 1;
          end
        end
        checked <= checked + 1;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SAMPLE_INTERVAL: cfg_si   = cfg_data[SiW-1:0];
          REG_HOLD_TICKS:      cfg_hold = cfg_data[HoldW-1:0];
          REG_REVERSE_TICKS:   cfg_rev  = cfg_data[RevW-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        due_outputs.push_back(lift_tick(pins_n));
    end
    pending <= due_outputs.size();
  end

endmodule

// File: tb/power_window_lift_controller_top_tb.sv
// ----------------------------------------------------------------------------
// power_window_lift_controller_top_tb
// Drives switch ticks and register writes into the window lift controller
// under random idling on both channels; a side checker predicts and compares
// every result. Prints the verdict at the end.
// ----------------------------------------------------------------------------
module power_window_lift_controller_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pwlc_pkg::*;

  localparam int unsigned CycleLimit = 300000;

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [PinW-1:0]    pins_n;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               motor_down;
  logic               motor_up;
  logic [1:0]         lamp;
  logic [3:0]         phase;
  logic               auto_mode;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgW-1:0]    cfg_data;

  int unsigned fails;
  int unsigned pending;
  int unsigned sent;       // ticks accepted so far
  int unsigned send_idle;  // percent of cycles the sender holds back
  int unsigned recv_idle;  // percent of cycles the receiver stalls
  int unsigned cycles;

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  power_window_lift_controller_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .pins_n     (pins_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .motor_down (motor_down),
    .motor_up   (motor_up),
    .lamp       (lamp),
    .phase      (phase),
    .auto_mode  (auto_mode),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  power_window_lift_controller_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .pins_n     (pins_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .motor_down (motor_down),
    .motor_up   (motor_up),
    .lamp       (lamp),
    .phase      (phase),
    .auto_mode  (auto_mode),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fails      (fails),
    .pending    (pending)
  );

  // receiver stalls, rerolled every cycle
  always @(negedge clk)
    out_ready <= ($urandom_range(0, 99) >= recv_idle);

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // One tick item. Entered and left at a falling edge. Valid stays high
  // between back-to-back items, so there is a single assignment per edge.
  task automatic send_item(input logic [PinW-1:0] pins);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    pins_n   <= pins;
    do @(posedge clk); while (!in_ready);
    sent++;
    @(negedge clk);
  endtask

  // Sender holds off until every expected result has come, then keeps waiting
  // so the result register is surely empty.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Writes all three registers back to back; only called while idle.
  task automatic load_settings(input logic [CfgW-1:0] si, input logic [CfgW-1:0] hold,
                               input logic [CfgW-1:0] rev);
    for (int k = 0; k < 3; k++) begin
      cfg_valid <= 1'b1;
      case (k)
        0: begin
          cfg_index <= REG_SAMPLE_INTERVAL;
          cfg_data  <= si;
        end
        1: begin
          cfg_index <= REG_HOLD_TICKS;
          cfg_data  <= hold;
        end
        default: begin
          cfg_index <= REG_REVERSE_TICKS;
          cfg_data  <= rev;
        end
      endcase
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // Hand-picked ticks, run with sample_interval 1, hold 3, reverse 4.
  task automatic play_directed();
    send_item(8'hFF);            // all released
    send_item(8'h00);            // every pin pressed: jam edge starts reverse
    send_item(8'hFF);            // jam released mid reverse
    send_item(8'hBF);            // second jam edge during reverse: ignored
    send_item(8'hFF);            // last reverse tick, then neutral
    repeat (2) send_item(8'h7E); // passenger up under lock: refused
    repeat (2) send_item(8'hFF);
    repeat (6) send_item(8'hF7); // driver down held past hold: manual run
    send_item(8'hD7);            // bottom limit ends it
    repeat (2) send_item(8'hFF);
    repeat (2) send_item(8'hFE); // passenger up tapped
    repeat (4) send_item(8'hFF); // released at decision: one-touch run
    send_item(8'hEF);            // top limit ends it
  endtask

  // A press / decide / stop sequence with random content. s and h are the
  // effective sample interval and hold, so the debouncer sees the press.
  task automatic play_gesture(input int unsigned s, input int unsigned h);
    logic [PinW-1:0] base;
    logic [PinW-1:0] pins;
    logic [PinW-1:0] last;
    int unsigned     btn;
    int unsigned     settle;
    base = 8'hFF;
    btn  = $urandom_range(0, BtnN - 1);
    if ($urandom_range(0, 4) == 0)
      base[LOCK_PIN] = 1'b0;
    settle    = 2 * s + 1;           // two agreeing samples
    pins      = base;
    pins[btn] = 1'b0;
    repeat (settle + $urandom_range(0, s)) send_item(pins);
    // keep holding for a manual run, or let go for a one-touch run
    last = ($urandom_range(0, 1) != 0) ? pins : base;
    repeat (h + $urandom_range(0, 6)) send_item(last);
    case ($urandom_range(0, 4))
      0: last[4 + $urandom_range(0, 1)] = 1'b0;   // a limit switch
      1: last[$urandom_range(0, BtnN - 1)] = 1'b0; // another button
      2: last[LOCK_PIN] = 1'b0;
      3: last[JAM_PIN] = 1'b0;
      default: ;
    endcase
    repeat ($urandom_range(1, 3)) send_item(last);
    repeat (settle + $urandom_range(0, 3)) send_item(8'hFF);
  endtask

  // Mostly gestures, the rest raw noise. With quiet set, only noise with
  // the jam pin held released.
  task automatic play_random(input int unsigned goal, input int unsigned s,
                             input int unsigned h, input logic quiet);
    logic [PinW-1:0] pins;
    while (sent < goal) begin
      if (quiet || $urandom_range(0, 99) < 20) begin
        pins = PinW'($urandom_range(0, 255));
        if (quiet || $urandom_range(0, 3) != 0)
          pins[JAM_PIN] = 1'b1;
        send_item(pins);
      end else begin
        play_gesture(s, h);
      end
    end
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    pins_n    = 8'hFF;
    cfg_valid = 1'b0;
    cfg_index = REG_SAMPLE_INTERVAL;
    cfg_data  = '0;
    cycles    = 0;
    sent      = 0;
    send_idle = 0;
    recv_idle = 0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // sender idles a third of the time, receiver mostly stalled
    send_idle = 33;
    recv_idle = 72;

    // short reverse first: the reset value would take a million ticks
    load_settings(24'd1, 24'd3, 24'd4);
    play_directed();
    wait_drained();

    load_settings(24'd2, 24'd8, 24'd10);
    play_random(sent + 150, 2, 8, 1'b0);
    wait_drained();                       // pause with nothing in flight
    play_random(sent + 150, 2, 8, 1'b0);
    wait_drained();

    // the other way round, zero registers (each acts as 1)
    send_idle = 72;
    recv_idle = 33;
    load_settings(24'd0, 24'd0, 24'd0);
    play_random(sent + 250, 1, 1, 1'b0);
    wait_drained();

    // no idling from here on
    send_idle = 0;
    recv_idle = 0;
    load_settings(24'd3, 24'd20, 24'd30);
    play_random(sent + 250, 3, 20, 1'b0);
    wait_drained();

    load_settings(24'd1, 24'd1, 24'd1);
    play_random(sent + 100, 1, 1, 1'b0);
    wait_drained();

    // top of every register; jam stays released so the reverse never starts
    load_settings(24'd255, 24'd65535, 24'd16777215);
    play_random(sent + 150, 255, 65535, 1'b1);
    wait_drained();

    if (fails == 0 && pending == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// File: power_window_lift_controller_top.f
hw/rtl/pwlc_pkg.sv
hw/rtl/pwlc_debounce.sv
hw/rtl/pwlc_ctrl.sv
hw/rtl/power_window_lift_controller_top.sv
hw/rtl/pwlc_checker.sv
tb/power_window_lift_controller_checker.sv
tb/power_window_lift_controller_top_tb.sv
